>>> src/ffa_pkg.sv
// shared types and constants of the first-fit aligned range allocator
`default_nettype none

package ffa_pkg;

  localparam int unsigned MAX_RANGES = 64;
  localparam int unsigned CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned END_W      = ADDR_W + 1;
  localparam int unsigned CAND_W     = ADDR_W + 3;

  localparam logic [ADDR_W-1:0] PAGE_SIZE_RST = 32'd16777216;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_FREED     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } ffa_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND,
    S_FIT,
    S_SEL,
    S_DONE
  } ffa_state_e;

  typedef struct packed {
    logic calc_cand;
    logic calc_fit;
    logic shift_ins;
    logic shift_rem;
  } ffa_ctl_t;

endpackage

`default_nettype wire

>>> src/ffa_cell.sv
// one table entry cell: holds a range, checks its gap, shifts on insert or remove
`default_nettype none

module ffa_cell (
  input  wire                          clk_i,
  input  ffa_pkg::ffa_ctl_t            ctl_i,
  input  wire                          valid_i,
  input  wire                          tail_i,
  input  wire                          sel_i,
  input  wire                          above_i,
  input  wire  [ffa_pkg::END_W-1:0]    prev_end_i,
  input  wire  [ffa_pkg::ADDR_W-1:0]   left_start_i,
  input  wire  [ffa_pkg::ADDR_W-1:0]   left_len_i,
  input  wire  [ffa_pkg::END_W-1:0]    left_end_i,
  input  wire  [ffa_pkg::ADDR_W-1:0]   right_start_i,
  input  wire  [ffa_pkg::ADDR_W-1:0]   right_len_i,
  input  wire  [ffa_pkg::END_W-1:0]    right_end_i,
  input  wire  [ffa_pkg::ADDR_W-1:0]   new_start_i,
  input  wire  [ffa_pkg::ADDR_W-1:0]   new_len_i,
  input  wire  [ffa_pkg::END_W-1:0]    new_end_i,
  input  wire  [ffa_pkg::ADDR_W-1:0]   req_size_i,
  input  wire  [ffa_pkg::ADDR_W-1:0]   align_mask_i,
  input  wire  [ffa_pkg::ADDR_W-1:0]   free_off_i,
  input  wire  [ffa_pkg::ADDR_W-1:0]   page_size_i,
  output logic [ffa_pkg::ADDR_W-1:0]   start_o,
  output logic [ffa_pkg::ADDR_W-1:0]   len_o,
  output logic [ffa_pkg::END_W-1:0]    end_o,
  output logic [ffa_pkg::CAND_W-1:0]   cand_o,
  output logic                         fit_o,
  output logic                         match_o
);
  import ffa_pkg::*;

  logic [ADDR_W-1:0] start_q, start_d;
  logic [ADDR_W-1:0] len_q, len_d;
  logic [END_W-1:0]  end_q, end_d;
  logic [CAND_W-1:0] cand_q, cand_d, cand_sum, mask_ext, need;
  logic              fit_q, fit_d;
  logic              match_q, match_d;

  // round the previous range end up to the alignment
  assign mask_ext = {{(CAND_W-ADDR_W){1'b0}}, align_mask_i};
  assign cand_sum = {{(CAND_W-END_W){1'b0}}, prev_end_i} + mask_ext;
  assign cand_d   = cand_sum & ~mask_ext;
  assign match_d  = valid_i && (start_q == free_off_i) && (len_q == req_size_i);
  assign need     = cand_q + {{(CAND_W-ADDR_W){1'b0}}, req_size_i};

  always_comb begin
    if (valid_i) begin
      fit_d = need <= {{(CAND_W-ADDR_W){1'b0}}, start_q};
    end else if (tail_i) begin
      fit_d = need <= {{(CAND_W-ADDR_W){1'b0}}, page_size_i};
    end else begin
      fit_d = 1'b0;
    end
  end

  always_comb begin
    start_d = start_q;
    len_d   = len_q;
    end_d   = end_q;
    if (ctl_i.shift_ins) begin
      if (above_i) begin
        start_d = left_start_i;
        len_d   = left_len_i;
        end_d   = left_end_i;
      end else if (sel_i) begin
        start_d = new_start_i;
        len_d   = new_len_i;
        end_d   = new_end_i;
      end
    end else if (ctl_i.shift_rem) begin
      if (above_i || sel_i) begin
        start_d = right_start_i;
        len_d   = right_len_i;
        end_d   = right_end_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    len_q   <= len_d;
    end_q   <= end_d;
    if (ctl_i.calc_cand) begin
      cand_q  <= cand_d;
      match_q <= match_d;
    end
    if (ctl_i.calc_fit) begin
      fit_q <= fit_d;
    end
  end

  assign start_o = start_q;
  assign len_o   = len_q;
  assign end_o   = end_q;
  assign cand_o  = cand_q;
  assign fit_o   = fit_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

>>> src/first_fit_aligned_range_allocator.sv
// top level: command sequencer, row of range cells, first-hit select and result register
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tuser command, tdata size/alignment/offset
// m_axis    out  m_axis_tvalid/tready      tuser status, tdata offset
// cfg       in   cfg_valid/cfg_ready       cfg_data page_size
//
// after acceptance an item passes the candidate, fit check, first-hit select and
// table update states in order; candidate and fit results are held in the cell row
// one item is in flight at a time, so no new word is taken until that item is done
// the next is accepted while a result waits
// a stalled result holds the update stage until the output register frees up
// reset empties the table at once (count to zero) and sets page_size to 16 MiB
`default_nettype none

module first_fit_aligned_range_allocator (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [95:0] s_axis_tdata,  // request_size, alignment, range_offset
  input  wire  [0:0]  s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,  // offset
  output logic [2:0]  m_axis_tuser,  // status
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [31:0] cfg_data_i     // page_size
);
  import ffa_pkg::*;

  ffa_state_e state_q, state_d;
  ffa_ctl_t   ctl;

  logic [ADDR_W-1:0] page_q;
  logic              cmd_q;
  logic [ADDR_W-1:0] size_q, mask_q, off_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic [ADDR_W-1:0] cell_start [MAX_RANGES];
  logic [ADDR_W-1:0] cell_len   [MAX_RANGES];
  logic [END_W-1:0]  cell_end   [MAX_RANGES];
  logic [CAND_W-1:0] cell_cand  [MAX_RANGES];
  logic [MAX_RANGES-1:0] cell_fit, cell_match, cell_valid, cell_tail;

  logic [MAX_RANGES-1:0] hit_vec, hit_low, hit_upto;
  logic [MAX_RANGES-1:0] sel_q, above_q;
  logic [CAND_W-1:0]     cand_sel;
  logic [ADDR_W-1:0]     new_start_q;
  logic [END_W-1:0]      new_end_q;
  ffa_status_e           status_q, status_d;

  logic accept, load_sel, done_fire;
  logic out_valid_q;
  ffa_status_e out_status_q;
  logic [ADDR_W-1:0] out_off_q;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign done_fire = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_CAND;
      S_CAND:  state_d = S_FIT;
      S_FIT:   state_d = S_SEL;
      S_SEL:   state_d = S_DONE;
      S_DONE:  if (done_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ctl           = '0;
    load_sel      = 1'b0;
    case (state_q)
      S_IDLE: s_axis_tready = 1'b1;
      S_CAND: ctl.calc_cand = 1'b1;
      S_FIT:  ctl.calc_fit  = 1'b1;
      S_SEL:  load_sel      = 1'b1;
      S_DONE: begin
        ctl.shift_ins = done_fire && (status_q == ST_ALLOCATED);
        ctl.shift_rem = done_fire && (status_q == ST_FREED);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      page_q  <= PAGE_SIZE_RST;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        page_q <= cfg_data_i;
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cnt_d = cnt_q;
    if (ctl.shift_ins) begin
      cnt_d = cnt_q + 1'b1;
    end else if (ctl.shift_rem) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_axis_tuser[0];
      size_q <= s_axis_tdata[31:0];
      // zero alignment acts as one
      mask_q <= (s_axis_tdata[63:32] == '0) ? '0 : s_axis_tdata[63:32] - 1'b1;
      off_q  <= s_axis_tdata[95:64];
    end
  end

  // the cell row
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    logic [END_W-1:0]  prev_end;
    logic [ADDR_W-1:0] l_start, l_len, r_start, r_len;
    logic [END_W-1:0]  l_end, r_end;

    assign cell_valid[i] = CNT_W'(i) < cnt_q;
    assign cell_tail[i]  = CNT_W'(i) == cnt_q;

    if (i == 0) begin : g_first
      assign prev_end = '0;
      assign l_start  = cell_start[i];
      assign l_len    = cell_len[i];
      assign l_end    = cell_end[i];
    end else begin : g_rest
      assign prev_end = cell_end[i-1];
      assign l_start  = cell_start[i-1];
      assign l_len    = cell_len[i-1];
      assign l_end    = cell_end[i-1];
    end

    if (i == MAX_RANGES - 1) begin : g_last
      assign r_start = cell_start[i];
      assign r_len   = cell_len[i];
      assign r_end   = cell_end[i];
    end else begin : g_inner
      assign r_start = cell_start[i+1];
      assign r_len   = cell_len[i+1];
      assign r_end   = cell_end[i+1];
    end

    ffa_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .valid_i      (cell_valid[i]),
      .tail_i       (cell_tail[i]),
      .sel_i        (sel_q[i]),
      .above_i      (above_q[i]),
      .prev_end_i   (prev_end),
      .left_start_i (l_start),
      .left_len_i   (l_len),
      .left_end_i   (l_end),
      .right_start_i(r_start),
      .right_len_i  (r_len),
      .right_end_i  (r_end),
      .new_start_i  (new_start_q),
      .new_len_i    (size_q),
      .new_end_i    (new_end_q),
      .req_size_i   (size_q),
      .align_mask_i (mask_q),
      .free_off_i   (off_q),
      .page_size_i  (page_q),
      .start_o      (cell_start[i]),
      .len_o        (cell_len[i]),
      .end_o        (cell_end[i]),
      .cand_o       (cell_cand[i]),
      .fit_o        (cell_fit[i]),
      .match_o      (cell_match[i])
    );
  end

  // first hit: lowest set bit and everything at or below it
  assign hit_vec  = (cmd_q == CMD_ALLOC) ? cell_fit : cell_match;
  assign hit_low  = hit_vec & (~hit_vec + 1'b1);
  assign hit_upto = hit_vec ^ (hit_vec - 1'b1);

  always_comb begin
    cand_sel = '0;
    for (int k = 0; k < MAX_RANGES; k++) begin
      cand_sel = cand_sel | (hit_low[k] ? cell_cand[k] : '0);
    end
  end

  always_comb begin
    if (cmd_q == CMD_ALLOC) begin
      if (size_q == '0) begin
        status_d = ST_NO_SPACE;
      end else if (cnt_q == CNT_W'(MAX_RANGES)) begin
        status_d = ST_FULL;
      end else if (hit_vec != '0) begin
        status_d = ST_ALLOCATED;
      end else begin
        status_d = ST_NO_SPACE;
      end
    end else begin
      status_d = (hit_vec != '0) ? ST_FREED : ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_sel) begin
      sel_q       <= hit_low;
      above_q     <= ~hit_upto;
      status_q    <= status_d;
      new_start_q <= cand_sel[ADDR_W-1:0];
      new_end_q   <= {1'b0, cand_sel[ADDR_W-1:0]} + {1'b0, size_q};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_status_q <= status_q;
      out_off_q    <= (status_q == ST_ALLOCATED) ? new_start_q : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_off_q;
  assign m_axis_tuser  = out_status_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RANGES))
    else $error("range count above table depth");

  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> $onehot0(sel_q))
    else $error("more than one cell selected");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.shift_ins |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("insert did not grow the table");

  a_full_no_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.shift_ins |-> cnt_q != CNT_W'(MAX_RANGES))
    else $error("insert into full table");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fire |=> (state_q == S_IDLE) && out_valid_q)
    else $error("result not presented after update");

endmodule

`default_nettype wire
